// File: hw/rtl/lenc_pkg.sv
// Shared types, codes and helpers for the length-delimited field encoder.
// No dependencies; imported by every module of the block.
package lenc_pkg;

	localparam logic FUNC_HDR  = 1'b0;
	localparam logic FUNC_DATA = 1'b1;

	localparam logic [2:0] WIRE_TYPE_LEN = 3'd2;
	localparam logic [7:0] VARINT_CONT   = 8'h80;
	localparam int         PREFIX_BYTES  = 4;

	typedef struct packed {
		logic        func;
		logic [28:0] field_num;
		logic [31:0] string_length;
		logic [7:0]  data_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       field_end;
		logic       overrun;
	} result_t;

	// Classified work passed from front to back
	typedef struct packed {
		logic        is_hdr;
		logic        prefix;
		logic [31:0] body;
		logic [31:0] tag;
		logic [31:0] slen;
		logic [7:0]  data;
		logic        fend;
		logic        ovr;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_PREFIX,
		BK_TAG,
		BK_LEN
	} bk_state_t;

	// Number of base-128 groups needed for a 32-bit value (1..5)
	function automatic logic [2:0] varint_len(input logic [31:0] v);
		logic [2:0] n;
		if (v[31:28] != '0)
			n = 3'd5;
		else if (v[27:21] != '0)
			n = 3'd4;
		else if (v[20:14] != '0)
			n = 3'd3;
		else if (v[13:7] != '0)
			n = 3'd2;
		else
			n = 3'd1;
		return n;
	endfunction

endpackage

// File: hw/rtl/length_delimited_field_encoder.sv
// Top level of the length-delimited field encoder: front, command queue, back.
// Depends on lenc_pkg, lenc_front, lenc_fifo and lenc_back.
//
//   channel   signals                      moves
//   input     push / full / item           header or string-byte item
//   result    pop / empty / result         one encoded byte with flags
//   config    cfg_valid / cfg_ready / cfg_data   frame prefix enable
//
// A data item passes straight through the back end, one byte per cycle while
// the result side is not stalled. A header item takes a load step in the back
// sequencer, then emits its bytes (2 to 14) one per cycle while not stalled.
// Reset clears the queue, the result valid flag, the remaining count and the
// prefix enable. The front keeps accepting while the queue has room, so a
// stalled result side only blocks input once the queue fills.
module length_delimited_field_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  lenc_pkg::item_t   item,
	input  logic              pop,
	output logic              empty,
	output lenc_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);
	import lenc_pkg::*;

	// front -> queue
	logic q_wr;
	logic q_full;
	cmd_t q_wdata;

	// queue -> back
	logic q_rd;
	logic q_empty;
	cmd_t q_rdata;

	assign full = q_full;

	// Front classifies items and keeps the string byte count
	lenc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.q_full    (q_full),
		.q_wr      (q_wr),
		.q_wdata   (q_wdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Decouples accept from byte emission
	lenc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// Back emits header bytes one per cycle unless stalled, data straight through
	lenc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_rdata (q_rdata),
		.q_rd    (q_rd),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

// File: hw/rtl/lenc_front.sv
// Front end: accepts items, tracks the remaining string count and builds commands.
// Depends on lenc_pkg.
module lenc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lenc_pkg::item_t item,
	input  logic           q_full,
	output logic           q_wr,
	output lenc_pkg::cmd_t q_wdata,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_data
);
	import lenc_pkg::*;

	logic        prefix_en_q;
	logic [31:0] remaining_q;
	logic [31:0] tag;
	logic [2:0]  n_tag;
	logic [2:0]  n_len;

	assign cfg_ready = 1'b1;
	assign q_wr      = push && !q_full;

	assign tag   = {item.field_num, WIRE_TYPE_LEN};
	assign n_tag = varint_len(tag);
	assign n_len = varint_len(item.string_length);

	always_comb begin
		q_wdata        = '0;
		q_wdata.is_hdr = (item.func == FUNC_HDR);
		q_wdata.prefix = prefix_en_q;
		q_wdata.body   = {29'd0, n_tag} + {29'd0, n_len} + item.string_length;
		q_wdata.tag    = tag;
		q_wdata.slen   = item.string_length;
		q_wdata.data   = item.data_byte;
		q_wdata.ovr    = (remaining_q == '0);
		q_wdata.fend   = (remaining_q == 32'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_en_q <= 1'b0;
			remaining_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				prefix_en_q <= cfg_data;
			if (q_wr) begin
				if (item.func == FUNC_HDR)
					remaining_q <= item.string_length;
				else if (remaining_q != '0)
					remaining_q <= remaining_q - 32'd1;
			end
		end
	end

endmodule

// File: hw/rtl/lenc_fifo.sv
// Short command queue between front and back.
// Depends on lenc_pkg.
module lenc_fifo #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  lenc_pkg::cmd_t wdata,
	output logic           full,
	input  logic           rd,
	output lenc_pkg::cmd_t rdata,
	output logic           empty
);
	import lenc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULLC = CW'(DEPTH);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == FULLC);
	assign empty = (count_q == '0);
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr)
			slot_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			if (rd)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			if (wr && !rd)
				count_q <= count_q + CW'(1);
			else if (rd && !wr)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

// File: hw/rtl/lenc_back.sv
// Back end: sequences prefix, tag and length bytes, passes data, holds the result register.
// Depends on lenc_pkg.
module lenc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  lenc_pkg::cmd_t    q_rdata,
	output logic              q_rd,
	input  logic              pop,
	output logic              empty,
	output lenc_pkg::result_t result
);
	import lenc_pkg::*;

	bk_state_t   state_q;
	bk_state_t   state_nxt;
	logic [1:0]  cnt_q;
	logic [31:0] body_q;
	logic [31:0] tag_q;
	logic [31:0] len_q;
	logic        zero_q;
	logic        out_valid_q;
	result_t     res_q;

	logic    adv;
	logic    emit;
	logic    tag_more;
	logic    len_more;
	logic    load;
	result_t res_nxt;

	assign adv      = !out_valid_q || pop;
	assign tag_more = (tag_q[31:7] != '0);
	assign len_more = (len_q[31:7] != '0);
	assign load     = (state_q == BK_IDLE) && q_rd && q_rdata.is_hdr;
	assign empty    = !out_valid_q;
	assign result   = res_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty && q_rdata.is_hdr)
					state_nxt = q_rdata.prefix ? BK_PREFIX : BK_TAG;
			end
			BK_PREFIX: begin
				if (adv && cnt_q == 2'(PREFIX_BYTES - 1))
					state_nxt = BK_TAG;
			end
			BK_TAG: begin
				if (adv && !tag_more)
					state_nxt = BK_LEN;
			end
			BK_LEN: begin
				if (adv && !len_more)
					state_nxt = BK_IDLE;
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_rd    = 1'b0;
		emit    = 1'b0;
		res_nxt = '0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					if (q_rdata.is_hdr) begin
						q_rd = 1'b1;
					end else if (adv) begin
						q_rd              = 1'b1;
						emit              = 1'b1;
						res_nxt.out_byte  = q_rdata.data;
						res_nxt.run_last  = 1'b1;
						res_nxt.field_end = q_rdata.fend && !q_rdata.ovr;
						res_nxt.overrun   = q_rdata.ovr;
					end
				end
			end
			BK_PREFIX: begin
				emit             = adv;
				res_nxt.out_byte = body_q[31:24];
			end
			BK_TAG: begin
				emit             = adv;
				res_nxt.out_byte = {tag_more, tag_q[6:0]};
			end
			BK_LEN: begin
				emit              = adv;
				res_nxt.out_byte  = {len_more, len_q[6:0]};
				res_nxt.run_last  = !len_more;
				res_nxt.field_end = !len_more && zero_q;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			body_q <= q_rdata.body;
			tag_q  <= q_rdata.tag;
			len_q  <= q_rdata.slen;
			zero_q <= (q_rdata.slen == '0);
		end else if (adv) begin
			if (state_q == BK_PREFIX)
				body_q <= {body_q[23:0], 8'd0};
			if (state_q == BK_TAG)
				tag_q <= {7'd0, tag_q[31:7]};
			if (state_q == BK_LEN)
				len_q <= {7'd0, len_q[31:7]};
		end
		if (emit)
			res_q <= res_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load)
				cnt_q <= '0;
			else if (adv && state_q == BK_PREFIX)
				cnt_q <= cnt_q + 2'd1;
			if (adv)
				out_valid_q <= emit;
		end
	end

endmodule

// File: hw/rtl/lenc_checker.sv
// Port-level checks for the length-delimited field encoder, bound to the top level.
// Depends on lenc_pkg and length_delimited_field_encoder.
module lenc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              pop,
	input logic              empty,
	input lenc_pkg::result_t result
);
	import lenc_pkg::*;

	// overrun only on a data byte, which is always a one-byte run
	a_ovr_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.overrun |-> result.run_last)
		else $error("overrun without run_last");

	// a field cannot end on an overrun byte
	a_ovr_fend: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(result.overrun && result.field_end))
		else $error("overrun and field_end together");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result withdrawn before pop");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(result))
		else $error("result changed while waiting");

endmodule

bind length_delimited_field_encoder lenc_checker u_lenc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.pop    (pop),
	.empty  (empty),
	.result (result)
);
